>>> sv/are_pkg.sv
package are_pkg;

  localparam int unsigned TableEntries   = 16;
  localparam int unsigned PendingEntries = 8;
  localparam logic [15:0] RetryReset     = 16'd500;

  localparam logic [47:0] MacBcast = 48'hFFFF_FFFF_FFFF;

  // Operation codes of the input word.
  localparam logic [1:0] OpRx     = 2'd0;
  localparam logic [1:0] OpLookup = 2'd1;
  localparam logic [1:0] OpTick   = 2'd2;

  // Result action codes.
  localparam logic [2:0] ActNone    = 3'd0;
  localparam logic [2:0] ActReply   = 3'd1;
  localparam logic [2:0] ActRequest = 3'd2;
  localparam logic [2:0] ActHit     = 3'd3;
  localparam logic [2:0] ActHeld    = 3'd4;
  localparam logic [2:0] ActUpdated = 3'd5;

  // Drop codes.
  localparam logic [2:0] DropNone     = 3'd0;
  localparam logic [2:0] DropShort    = 3'd1;
  localparam logic [2:0] DropTypes    = 3'd2;
  localparam logic [2:0] DropMismatch = 3'd3;
  localparam logic [2:0] DropNullTgt  = 3'd4;
  localparam logic [2:0] DropNullSnd  = 3'd5;
  localparam logic [2:0] DropUnsolic  = 3'd6;
  localparam logic [2:0] DropOpcode   = 3'd7;

  localparam logic [1:0] TxNone    = 2'd0;
  localparam logic [1:0] TxRequest = 2'd1;
  localparam logic [1:0] TxReply   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] RegOwnMac = 2'd0;
  localparam logic [1:0] RegOwnIp  = 2'd1;
  localparam logic [1:0] RegRetry  = 2'd2;

  // One result word.
  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  drop_reason;
    logic [47:0] resolved_mac;
    logic [1:0]  tx_opcode;
    logic [47:0] tx_dest_mac;
    logic [47:0] tx_target_mac;
    logic [31:0] tx_target_ip;
  } result_t;

endpackage

>>> sv/arp_resolver_engine_core.sv
// Steps: a tick, an unused op or a packet settled by its header checks goes from accept
// straight to the output step. A lookup walks the table memory one entry per cycle; a hit
// then reads the hit MAC, while a miss also walks the pending memory and decides the pending
// action. A checked reply walks both memories, decides its store slot and writes the table.
// Only one word is in the engine at a time; the next word is taken the cycle after its
// result moves to the output register.
// Reset: valid bits, time, replace pointer and control clear at once.
module arp_resolver_engine_core #(
  parameter int unsigned TABLE_ENTRIES   = are_pkg::TableEntries,
  parameter int unsigned PENDING_ENTRIES = are_pkg::PendingEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic        frame_long_enough_i,
  input  logic [15:0] hw_type_i,
  input  logic [15:0] proto_type_i,
  input  logic [7:0]  hw_size_i,
  input  logic [7:0]  proto_size_i,
  input  logic [15:0] arp_op_i,
  input  logic [47:0] sender_mac_i,
  input  logic [31:0] sender_ip_i,
  input  logic [31:0] target_ip_i,
  input  logic [47:0] eth_src_mac_i,
  input  logic [31:0] lookup_ip_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  action_o,
  output logic [2:0]  drop_reason_o,
  output logic [47:0] resolved_mac_o,
  output logic [1:0]  tx_opcode_o,
  output logic [47:0] tx_dest_mac_o,
  output logic [47:0] tx_target_mac_o,
  output logic [31:0] tx_target_ip_o
);

  localparam int unsigned TW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned PW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
  localparam int unsigned CW = (TW > PW) ? TW : PW;
  localparam logic [CW:0] TLast = (CW+1)'(TABLE_ENTRIES - 1);
  localparam logic [CW:0] PLast = (CW+1)'(PENDING_ENTRIES - 1);

  // Sequencer states.
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TSCAN = 4'd1;  // table scan: ip and mac match
  localparam logic [3:0] S_PSCAN = 4'd2;  // pending scan
  localparam logic [3:0] S_TDEC  = 4'd3;  // decide store slot
  localparam logic [3:0] S_TWR   = 4'd4;  // write table entries
  localparam logic [3:0] S_PDEC  = 4'd5;  // decide pending action
  localparam logic [3:0] S_HITRD = 4'd6;  // read hit mac
  localparam logic [3:0] S_HITWT = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [47:0] own_mac;
  logic [31:0] own_ip;
  logic [15:0] retry_ticks;

  are_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .own_mac_o(own_mac), .own_ip_o(own_ip), .retry_ticks_o(retry_ticks)
  );

  // Memories with registered read data.
  logic [31:0] t_ip_mem  [TABLE_ENTRIES];
  logic [47:0] t_mac_mem [TABLE_ENTRIES];
  logic [31:0] p_ip_mem  [PENDING_ENTRIES];
  logic [31:0] p_tm_mem  [PENDING_ENTRIES];
  logic [TABLE_ENTRIES-1:0]   t_valid_q;
  logic [PENDING_ENTRIES-1:0] p_valid_q;

  logic [TW-1:0] t_raddr, t_waddr;
  logic          t_we;
  logic [31:0]   t_wip, t_rip_q;
  logic [47:0]   t_wmac, t_rmac_q;
  logic [PW-1:0] p_raddr, p_waddr;
  logic          p_we, p_we_ip;
  logic [31:0]   p_wip, p_wtm, p_rip_q, p_rtm_q;

  always_ff @(posedge clk_i) begin
    if (t_we) begin
      t_ip_mem[t_waddr]  <= t_wip;
      t_mac_mem[t_waddr] <= t_wmac;
    end
    t_rip_q  <= t_ip_mem[t_raddr];
    t_rmac_q <= t_mac_mem[t_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (p_we) begin
      p_tm_mem[p_waddr] <= p_wtm;
      if (p_we_ip) p_ip_mem[p_waddr] <= p_wip;
    end
    p_rip_q <= p_ip_mem[p_raddr];
    p_rtm_q <= p_tm_mem[p_raddr];
  end

  // Control and scan registers.
  logic [3:0]  st_q, st_d;
  logic [CW:0] cnt_q, cnt_d;       // issue index, one wider to count past end
  logic        rd_v_q, rd_v_d;     // read data valid next cycle
  logic [CW:0] rd_i_q, rd_i_d;     // index of data in read register
  logic [31:0] time_q;
  logic [TW-1:0] rp_q;
  logic        ip_f_q, mac_f_q, free_f_q, p_f_q, pfree_f_q;
  logic [TW-1:0] ip_i_q, mac_i_q, free_i_q;
  logic [PW-1:0] p_i_q, pfree_i_q, old_i_q;
  logic [31:0] old_age_q;
  logic [31:0] pend_tm_q;
  logic [47:0] smac_q;
  logic [31:0] key_q;
  logic        is_lookup_q;
  are_pkg::result_t res_q;
  are_pkg::result_t res_out_q;
  logic        out_v_q;
  logic        out_free;

  logic acc, take;
  logic [2:0]  pre_drop;
  logic        pre_reply, pre_skip;
  assign in_stall_o = (st_q != S_IDLE);
  assign acc  = in_valid_i && !in_stall_o;
  assign take = out_v_q && !out_stall_i;
  assign out_free = !out_v_q || take;

  // Header checks done at accept time.
  always_comb begin
    pre_drop  = are_pkg::DropNone;
    pre_reply = 1'b0;
    pre_skip  = 1'b1;
    if (!frame_long_enough_i) pre_drop = are_pkg::DropShort;
    else if (hw_type_i != 16'd1 || proto_type_i != 16'h0800 ||
             hw_size_i != 8'd6 || proto_size_i != 8'd4) pre_drop = are_pkg::DropTypes;
    else if (sender_mac_i != eth_src_mac_i) pre_drop = are_pkg::DropMismatch;
    else if (arp_op_i == 16'd1) begin
      if (target_ip_i == 32'd0) pre_drop = are_pkg::DropNullTgt;
      else if (target_ip_i == own_ip) pre_reply = 1'b1;
    end else if (arp_op_i == 16'd2) begin
      if (sender_ip_i == 32'd0) pre_drop = are_pkg::DropNullSnd;
      else pre_skip = 1'b0;
    end else pre_drop = are_pkg::DropOpcode;
  end

  // Result word as known at accept time.
  are_pkg::result_t res_acc;
  always_comb begin
    res_acc = '0;
    if (op_i == are_pkg::OpRx) begin
      res_acc.drop_reason = pre_drop;
      if (pre_reply) begin
        res_acc.action        = are_pkg::ActReply;
        res_acc.tx_opcode     = are_pkg::TxReply;
        res_acc.tx_dest_mac   = sender_mac_i;
        res_acc.tx_target_mac = sender_mac_i;
        res_acc.tx_target_ip  = sender_ip_i;
      end
    end
  end

  logic [31:0] age;
  assign age = time_q - p_rtm_q;
  logic [31:0] page;
  assign page = time_q - pend_tm_q;
  logic [TW-1:0] slot;
  logic [PW-1:0] pslot;
  logic [TABLE_ENTRIES-1:0] t_valid_nx;

  always_comb begin
    if (ip_f_q)        slot = ip_i_q;
    else if (mac_f_q)  slot = mac_i_q;
    else if (free_f_q) slot = free_i_q;
    else               slot = rp_q;
    if (pfree_f_q) pslot = pfree_i_q;
    else           pslot = old_i_q;
  end

  // Table valid bits after a store: a clashing MAC entry drops out.
  always_comb begin
    t_valid_nx = t_valid_q;
    if (ip_f_q && mac_f_q && ip_i_q != mac_i_q) t_valid_nx[mac_i_q] = 1'b0;
    t_valid_nx[slot] = 1'b1;
  end

  always_comb begin
    st_d    = st_q;
    cnt_d   = cnt_q;
    rd_v_d  = 1'b0;
    rd_i_d  = cnt_q;
    t_raddr = cnt_q[TW-1:0];
    p_raddr = cnt_q[PW-1:0];
    t_we = 1'b0; t_waddr = slot; t_wip = key_q; t_wmac = smac_q;
    p_we = 1'b0; p_we_ip = 1'b0; p_waddr = pslot; p_wip = key_q; p_wtm = time_q;
    case (st_q)
      S_IDLE: begin
        if (acc) begin
          cnt_d = '0;
          if (op_i == are_pkg::OpLookup || (op_i == are_pkg::OpRx && !pre_skip))
            st_d = S_TSCAN;
          else st_d = S_OUT;
        end
      end
      S_TSCAN: begin
        if (cnt_q <= TLast) begin
          rd_v_d = 1'b1;
          cnt_d  = cnt_q + 1'b1;
        end else if (!rd_v_q) begin
          cnt_d = '0;
          if (is_lookup_q) st_d = ip_f_q ? S_HITRD : S_PSCAN;
          else st_d = S_PSCAN;
        end
      end
      S_PSCAN: begin
        if (cnt_q <= PLast) begin
          rd_v_d = 1'b1;
          cnt_d  = cnt_q + 1'b1;
        end else if (!rd_v_q) begin
          st_d = is_lookup_q ? S_PDEC : S_TDEC;
        end
      end
      S_TDEC: st_d = S_TWR;
      S_TWR: begin
        st_d = S_OUT;
        if (p_f_q) begin
          t_we = 1'b1;
        end
      end
      S_HITRD: begin
        t_raddr = ip_i_q;
        st_d    = S_HITWT;
      end
      S_HITWT: st_d = S_OUT;
      S_PDEC: begin
        st_d = S_OUT;
        if (!p_f_q) begin
          p_we = 1'b1; p_we_ip = 1'b1;
        end else if (page >= {16'd0, retry_ticks}) begin
          p_we = 1'b1; p_waddr = p_i_q;
        end
      end
      S_OUT: begin
        if (out_free) st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; cnt_q <= '0; rd_v_q <= 1'b0; rd_i_q <= '0;
      time_q <= '0; rp_q <= '0; t_valid_q <= '0; p_valid_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      rd_v_q <= rd_v_d;
      rd_i_q <= rd_i_d;
      if (acc && op_i == are_pkg::OpTick) time_q <= time_q + 32'd1;
      // Table commit of a solicited reply.
      if (st_q == S_TWR && p_f_q) begin
        p_valid_q[p_i_q] <= 1'b0;
        t_valid_q <= t_valid_nx;
        if (!ip_f_q && !mac_f_q && !free_f_q)
          rp_q <= (rp_q == TLast[TW-1:0]) ? '0 : rp_q + 1'b1;
      end
      if (st_q == S_PDEC && !p_f_q) p_valid_q[pslot] <= 1'b1;
      if (st_q == S_OUT && out_free) out_v_q <= 1'b1;
      else if (take) out_v_q <= 1'b0;
    end
  end

  // Scan bookkeeping and result build.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      ip_f_q <= 1'b0; mac_f_q <= 1'b0; free_f_q <= 1'b0;
      p_f_q <= 1'b0; pfree_f_q <= 1'b0;
      old_age_q <= '0; old_i_q <= '0;
      is_lookup_q <= (op_i == are_pkg::OpLookup);
      key_q  <= (op_i == are_pkg::OpLookup) ? lookup_ip_i : sender_ip_i;
      smac_q <= sender_mac_i;
      res_q  <= res_acc;
    end
    if (rd_v_q && st_q == S_TSCAN) begin
      if (t_valid_q[rd_i_q[TW-1:0]]) begin
        if (!ip_f_q && t_rip_q == key_q) begin
          ip_f_q <= 1'b1; ip_i_q <= rd_i_q[TW-1:0];
        end
        if (!mac_f_q && t_rmac_q == smac_q) begin
          mac_f_q <= 1'b1; mac_i_q <= rd_i_q[TW-1:0];
        end
      end else if (!free_f_q) begin
        free_f_q <= 1'b1; free_i_q <= rd_i_q[TW-1:0];
      end
    end
    if (rd_v_q && st_q == S_PSCAN) begin
      if (p_valid_q[rd_i_q[PW-1:0]]) begin
        if (!p_f_q && p_rip_q == key_q) begin
          p_f_q <= 1'b1; p_i_q <= rd_i_q[PW-1:0]; pend_tm_q <= p_rtm_q;
        end
        if (rd_i_q == '0 || age > old_age_q) begin
          old_age_q <= age; old_i_q <= rd_i_q[PW-1:0];
        end
      end else if (!pfree_f_q) begin
        pfree_f_q <= 1'b1; pfree_i_q <= rd_i_q[PW-1:0];
      end
    end
    if (st_q == S_TDEC) begin
      if (p_f_q) res_q.action <= are_pkg::ActUpdated;
      else res_q.drop_reason <= are_pkg::DropUnsolic;
    end
    if (st_q == S_HITWT) begin
      res_q.action       <= are_pkg::ActHit;
      res_q.resolved_mac <= t_rmac_q;
    end
    if (st_q == S_PDEC) begin
      if (!p_f_q || page >= {16'd0, retry_ticks}) begin
        res_q.action       <= are_pkg::ActRequest;
        res_q.tx_opcode    <= are_pkg::TxRequest;
        res_q.tx_dest_mac  <= are_pkg::MacBcast;
        res_q.tx_target_ip <= key_q;
      end else res_q.action <= are_pkg::ActHeld;
    end
    // A finished word moves to the output register once it is free.
    if (st_q == S_OUT && out_free) res_out_q <= res_q;
  end

  assign out_valid_o     = out_v_q;
  assign action_o        = res_out_q.action;
  assign drop_reason_o   = res_out_q.drop_reason;
  assign resolved_mac_o  = res_out_q.resolved_mac;
  assign tx_opcode_o     = res_out_q.tx_opcode;
  assign tx_dest_mac_o   = res_out_q.tx_dest_mac;
  assign tx_target_mac_o = res_out_q.tx_target_mac;
  assign tx_target_ip_o  = res_out_q.tx_target_ip;

endmodule

>>> sv/are_cfg.sv
module are_cfg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output logic [47:0] own_mac_o,
  output logic [31:0] own_ip_o,
  output logic [15:0] retry_ticks_o
);

  logic [47:0] own_mac_q;
  logic [31:0] own_ip_q;
  logic [15:0] retry_q;
  logic [1:0]  idx;
  logic        hi_zero;

  assign idx     = paddr[4:3];
  assign hi_zero = (paddr[2:0] == 3'd0);
  assign pready  = 1'b1;

  // Register writes on the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_mac_q <= '0;
      own_ip_q  <= '0;
      retry_q   <= are_pkg::RetryReset;
    end else if (psel && penable && pwrite && hi_zero) begin
      case (idx)
        are_pkg::RegOwnMac: own_mac_q <= pwdata[47:0];
        are_pkg::RegOwnIp:  own_ip_q  <= pwdata[31:0];
        are_pkg::RegRetry:  retry_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    prdata = '0;
    if (hi_zero) begin
      case (idx)
        are_pkg::RegOwnMac: prdata = {16'd0, own_mac_q};
        are_pkg::RegOwnIp:  prdata = {32'd0, own_ip_q};
        are_pkg::RegRetry:  prdata = {48'd0, retry_q};
        default:            prdata = '0;
      endcase
    end
  end

  assign own_mac_o     = own_mac_q;
  assign own_ip_o      = own_ip_q;
  assign retry_ticks_o = retry_q;

endmodule

>>> sv/are_checker.sv
module are_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] action_o,
  input logic [2:0] drop_reason_o,
  input logic [1:0] tx_opcode_o
);

  // A held result keeps its action.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(action_o))
    else $error("result changed while stalled");

  // Handshake outputs are always known out of reset.
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({in_stall_o, out_valid_o}))
    else $error("handshake output unknown");

  // A drop never orders a transmit and carries no action.
  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && drop_reason_o != are_pkg::DropNone |->
      tx_opcode_o == are_pkg::TxNone && action_o == are_pkg::ActNone)
    else $error("dropped word sends a packet");

  // A send request carries the request opcode.
  a_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == are_pkg::ActRequest |-> tx_opcode_o == are_pkg::TxRequest)
    else $error("request without opcode");

endmodule

bind arp_resolver_engine_core are_checker u_are_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .action_o, .drop_reason_o, .tx_opcode_o
);
